// File: rtl/core/signed_int_to_radix_digits_defines.svh
// Assertion helpers for the radix conversion block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH

// Same-cycle implication
`define SIRAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SIRAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sirad_pkg.sv
`default_nettype none

package sirad_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned MaxDigits    = 16;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [4:0] MinRadix  = 5'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgDigitCount = 2'd0;
  localparam logic [1:0] CfgCharsLo    = 2'd1;
  localparam logic [1:0] CfgCharsHi    = 2'd2;

  // Divider commands from the sequencer
  typedef struct packed {
    logic load;
    logic step;
    logic restart;
  } div_ctrl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic       last_bit;
    logic       mag_zero;
    logic [3:0] rem;
  } div_stat_t;

  // Pick one alphabet byte out of the two packed registers
  function automatic logic [7:0] alpha_char(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_int_to_radix_digits.sv
// After start the alphabet is checked; the bit-serial radix divider then gives the digits
// least significant first onto the digit stack, and they come out most significant first,
// a leading minus directly before them, then one character per cycle. busy stays high
// until the last character is issued, so no new request is taken until then. An invalid
// alphabet holds busy for one cycle and gives no characters. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the sequencer and the configuration registers;
// the digit stack holds no reset value.
`default_nettype none

module signed_int_to_radix_digits
  import sirad_pkg::*;
#(
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [ValueBits-1:0] value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i,
  output logic                      out_valid_o,
  output logic [7:0]                out_char_o,
  output logic                      last_char_o
);

  `include "signed_int_to_radix_digits_defines.svh"

  localparam int unsigned AddrW = $clog2(ValueBits);
  localparam int unsigned NumW  = $clog2(ValueBits + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_PRIME = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [4:0]           digit_count_q;
  logic [63:0]          chars_lo_q, chars_hi_q;
  logic                 neg_q, neg_d;
  logic [NumW-1:0]      num_q, num_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 last_q, last_d;
  logic                 accept;
  logic                 alpha_ok;
  logic [ValueBits-1:0] mag;
  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_raddr;
  logic [3:0]           ram_rdata;
  logic [NumW-1:0]      num_dec;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != S_IDLE);
  assign num_dec = num_q - 1'b1;

  // Magnitude at full width, so the most negative value needs no extra bit
  assign mag = value_i[ValueBits-1] ? (~value_i + 1'b1) : value_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= '0;
      chars_lo_q    <= '0;
      chars_hi_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDigitCount: digit_count_q <= cfg_data_i[4:0];
        CfgCharsLo:    chars_lo_q    <= cfg_data_i;
        CfgCharsHi:    chars_hi_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sirad_alpha_chk u_alpha_chk (
    .digit_count_i (digit_count_q),
    .chars_lo_i    (chars_lo_q),
    .chars_hi_i    (chars_hi_q),
    .ok_o          (alpha_ok)
  );

  sirad_div #(
    .ValueBits (ValueBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .mag_i   (mag),
    .radix_i (digit_count_q),
    .stat_o  (div_stat)
  );

  // Digit stack, least significant digit at address zero
  sirad_ram #(
    .Width (4),
    .Depth (ValueBits)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (num_q[AddrW-1:0]),
    .wdata_i (div_stat.rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d          = state_q;
    neg_d            = neg_q;
    num_d            = num_q;
    div_ctrl         = '0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = num_dec[AddrW-1:0];
    out_valid_d      = 1'b0;
    out_char_d       = out_char_q;
    last_d           = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          div_ctrl.load = 1'b1;
          neg_d         = value_i[ValueBits-1];
          num_d         = '0;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = alpha_ok ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        div_ctrl.step = 1'b1;
        if (div_stat.last_bit) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        ram_we = 1'b1;
        num_d  = num_q + 1'b1;
        if (div_stat.mag_zero) begin
          state_d = neg_q ? S_SIGN : S_PRIME;
        end else begin
          div_ctrl.restart = 1'b1;
          state_d          = S_DIV;
        end
      end
      S_SIGN, S_PRIME: begin
        ram_re  = 1'b1;
        num_d   = num_dec;
        state_d = S_EMIT;
        if (state_q == S_SIGN) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
        end
      end
      S_EMIT: begin
        out_valid_d = 1'b1;
        out_char_d  = alpha_char(chars_lo_q, chars_hi_q, ram_rdata);
        last_d      = (num_q == '0);
        if (num_q == '0) begin
          state_d = S_IDLE;
        end else begin
          ram_re = 1'b1;
          num_d  = num_dec;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      num_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      num_q       <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_valid_q && last_q;

  // Checks
  `SIRAD_ASSERT_NEXT(a_start_checks, accept, state_q == S_CHECK,
                     "accepted request did not enter the alphabet check")
  `SIRAD_ASSERT_NOW(a_last_idle, out_valid_o && last_char_o, state_q == S_IDLE,
                    "sequencer still busy after the final character")
  `SIRAD_ASSERT_NOW(a_stack_room, state_q == S_STORE, num_q < NumW'(ValueBits),
                    "digit stack overflow")
  `SIRAD_ASSERT_NOW(a_rem_range, state_q == S_STORE, ({1'b0, div_stat.rem} < digit_count_q),
                    "remainder not below the radix")

endmodule

`default_nettype wire

// File: rtl/core/sirad_ram.sv
`default_nettype none

module sirad_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sirad_alpha_chk.sv
`default_nettype none

module sirad_alpha_chk
  import sirad_pkg::*;
(
  input  wire logic [4:0]  digit_count_i,
  input  wire logic [63:0] chars_lo_i,
  input  wire logic [63:0] chars_hi_i,
  output logic             ok_o
);

  logic count_ok;
  logic bad_char;
  logic dup_char;

  assign count_ok = (digit_count_i >= MinRadix) && (digit_count_i <= 5'(MaxDigits));

  // Sign characters and repeated bytes among the digits in use
  always_comb begin
    logic [7:0] ci;
    bad_char = 1'b0;
    dup_char = 1'b0;
    for (int i = 0; i < 16; i++) begin
      ci = alpha_char(chars_lo_i, chars_hi_i, 4'(i));
      if (5'(i) < digit_count_i) begin
        if ((ci == CharMinus) || (ci == CharPlus)) begin
          bad_char = 1'b1;
        end
        for (int j = i + 1; j < 16; j++) begin
          if ((5'(j) < digit_count_i) &&
              (alpha_char(chars_lo_i, chars_hi_i, 4'(j)) == ci)) begin
            dup_char = 1'b1;
          end
        end
      end
    end
  end

  assign ok_o = count_ok && !bad_char && !dup_char;

endmodule

`default_nettype wire

// File: rtl/core/sirad_div.sv
`default_nettype none

// Restoring divider by the radix, one dividend bit per cycle.
// The dividend register is shifted in place and ends up holding the quotient.
module sirad_div
  import sirad_pkg::*;
#(
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire div_ctrl_t            ctrl_i,
  input  wire logic [ValueBits-1:0] mag_i,
  input  wire logic [4:0]           radix_i,
  output div_stat_t                 stat_o
);

  localparam int unsigned CntW = $clog2(ValueBits);

  logic [ValueBits-1:0] mag_q, mag_d;
  logic [3:0]           rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [4:0]           trial;
  logic                 fits;

  // Shared compare-subtract step
  assign trial = {rem_q, mag_q[ValueBits-1]};
  assign fits  = (trial >= radix_i);

  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      mag_d = mag_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.restart) begin
      rem_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      mag_d = {mag_q[ValueBits-2:0], fits};
      rem_d = fits ? 4'(trial - radix_i) : trial[3:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign stat_o.last_bit = (cnt_q == CntW'(ValueBits - 1));
  assign stat_o.mag_zero = (mag_q == '0);
  assign stat_o.rem      = rem_q;

endmodule

`default_nettype wire
